### hdl/bfa_pkg.sv
// shared types and constants for the best-fit aligned chunk allocator
// used by bfa_cell and the top level; no dependencies
package bfa_pkg;

	localparam int ADDR_W = 48;
	localparam int SIZE_W = 40;
	localparam int ALOG_W = 5;
	localparam int AM_W   = 31;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_SMALL = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	localparam logic [1:0] CMD_HOLD   = 2'd0;
	localparam logic [1:0] CMD_EVAL   = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic [1:0] CMD_INSERT = 2'd3;

	typedef struct packed {
		logic              v;
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] len;
	} chunk_t;

	// broadcast to every cell: len is the insert length or the wanted size
	typedef struct packed {
		logic [1:0]        op;
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] len;
		logic [AM_W-1:0]   amask;
	} cell_cmd_t;

endpackage

### hdl/bfa_cell.sv
// one slot of the length-ordered chunk chain
// depends on bfa_pkg; neighbors pass chunks for shifting and le/found chains
module bfa_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  bfa_pkg::cell_cmd_t cmd,
	input  bfa_pkg::chunk_t   left,
	input  bfa_pkg::chunk_t   right,
	input  logic              le_left,
	input  logic              found_left,
	output bfa_pkg::chunk_t   chunk,
	output logic              le,
	output logic              found,
	output logic [bfa_pkg::ADDR_W-1:0] sel_start,
	output logic [bfa_pkg::SIZE_W-1:0] sel_len
);
	import bfa_pkg::*;

	logic              v_q;
	logic [ADDR_W-1:0] start_q;
	logic [SIZE_W-1:0] len_q;
	logic              hit_q;
	logic [ADDR_W:0]   astart;
	logic [ADDR_W:0]   aend;
	logic [ADDR_W:0]   cend;
	logic              fit;
	logic              first;

	always_comb begin
		astart = ({1'b0, start_q} + {{(ADDR_W+1-AM_W){1'b0}}, cmd.amask})
			& ~{{(ADDR_W+1-AM_W){1'b0}}, cmd.amask};
		aend = astart + {{(ADDR_W+1-SIZE_W){1'b0}}, cmd.len};
		cend = {1'b0, start_q} + {{(ADDR_W+1-SIZE_W){1'b0}}, len_q};
		// aligned block must stay below the address limit and inside the chunk
		fit = v_q && (len_q >= cmd.len) && !astart[ADDR_W]
			&& (aend <= {1'b1, {ADDR_W{1'b0}}}) && (aend <= cend);
	end

	assign chunk     = '{v: v_q, start: start_q, len: len_q};
	assign le        = v_q && (len_q <= cmd.len);
	assign found     = found_left | hit_q;
	assign first     = hit_q & ~found_left;
	assign sel_start = first ? start_q : '0;
	assign sel_len   = first ? len_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				CMD_EVAL: begin
					hit_q <= fit;
				end
				CMD_REMOVE: begin
					if (found)
						v_q <= right.v;
					hit_q <= 1'b0;
				end
				CMD_INSERT: begin
					if (!le)
						v_q <= le_left ? 1'b1 : left.v;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CMD_REMOVE: begin
				if (found) begin
					start_q <= right.start;
					len_q   <= right.len;
				end
			end
			CMD_INSERT: begin
				if (!le) begin
					start_q <= le_left ? cmd.start : left.start;
					len_q   <= le_left ? cmd.len : left.len;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### hdl/best_fit_aligned_chunk_allocator.sv
// best-fit aligned chunk allocator: free chunks held in a chain of cells sorted by length
// allocate: evaluate, pick, align, two remnant inserts, out; evaluate, pick, out when none fits
// free: check, insert, out (check, out when ignored); next request taken after result leaves
// arst_n clears the chunk count, cell valid bits and the sequencer; chunk data is not reset
// depends on bfa_pkg and bfa_cell
module best_fit_aligned_chunk_allocator #(
	parameter int CHUNK_SLOTS     = 64,
	parameter int NODE_BYTES      = 32,
	parameter int NODE_ALIGN_LOG2 = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [bfa_pkg::ADDR_W-1:0]    address,
	input  logic [bfa_pkg::SIZE_W-1:0]    size,
	input  logic [bfa_pkg::ALOG_W-1:0]    align_log2,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bfa_pkg::ADDR_W-1:0]    alloc_address,
	output logic [1:0]                    status
);
	import bfa_pkg::*;

	localparam int CW = $clog2(CHUNK_SLOTS + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(CHUNK_SLOTS);
	localparam logic [SIZE_W-1:0] NB = SIZE_W'(NODE_BYTES);
	localparam logic [ADDR_W:0] NB49 = (ADDR_W+1)'(NODE_BYTES);
	localparam logic [ADDR_W:0] NA_M1 = (ADDR_W+1)'((1 << NODE_ALIGN_LOG2) - 1);
	localparam logic [ADDR_W:0] LIMIT = {1'b1, {ADDR_W{1'b0}}};
	localparam logic [ALOG_W-1:0] NAL = ALOG_W'(NODE_ALIGN_LOG2);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_PICK = 3'd2;
	localparam logic [2:0] S_CALC = 3'd3;
	localparam logic [2:0] S_INS1 = 3'd4;
	localparam logic [2:0] S_INS2 = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;
	localparam logic [2:0] S_FCHK = 3'd7;

	logic [2:0]        state_q;
	logic [CW-1:0]     count_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SIZE_W-1:0] sz_q;
	logic [AM_W-1:0]   am_q;
	logic [ADDR_W-1:0] sel_start_q;
	logic [SIZE_W-1:0] sel_len_q;
	logic [ADDR_W-1:0] pre_start_q;
	logic [SIZE_W-1:0] pre_len_q;
	logic              pre_ok_q;
	logic [ADDR_W-1:0] suf_start_q;
	logic [SIZE_W-1:0] suf_len_q;
	logic              suf_ok_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [1:0]        status_q;

	cell_cmd_t cmd;
	chunk_t    chunks [CHUNK_SLOTS];
	logic [CHUNK_SLOTS-1:0] le_v;
	logic [CHUNK_SLOTS-1:0] found_v;
	logic [CHUNK_SLOTS-1:0] cell_v;
	logic [ADDR_W-1:0] sel_start [CHUNK_SLOTS];
	logic [SIZE_W-1:0] sel_len [CHUNK_SLOTS];
	logic [ADDR_W-1:0] pick_start;
	logic [SIZE_W-1:0] pick_len;

	logic              accept;
	logic [SIZE_W-1:0] sz_eff;
	logic [ALOG_W-1:0] alog_eff;
	logic [31:0]       a_full;
	logic [ADDR_W:0]   bstart;
	logic [ADDR_W:0]   bend;
	logic              free_bad;
	logic [ADDR_W:0]   astart;
	logic [ADDR_W:0]   aend;
	logic [ADDR_W:0]   cend;
	logic [ADDR_W:0]   suf_diff;
	logic [ADDR_W-1:0] pre_diff;
	logic              full;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign alloc_address = res_addr_q;
	assign status = status_q;
	assign full = (count_q == FULL_CNT);

	always_comb begin
		sz_eff   = (size < NB) ? NB : size;
		alog_eff = (align_log2 < NAL) ? NAL : align_log2;
		a_full   = 32'(1) << alog_eff;
	end

	// free region aligned inward to the node alignment
	always_comb begin
		bstart = ({1'b0, addr_q} + NA_M1) & ~NA_M1;
		bend   = ({1'b0, addr_q} + {{(ADDR_W+1-SIZE_W){1'b0}}, sz_q}) & ~NA_M1;
		free_bad = (sz_q == '0) || ((bstart + NB49) > LIMIT) || (bend > LIMIT)
			|| (bend < (bstart + NB49));
	end

	always_comb begin
		astart = ({1'b0, sel_start_q} + {{(ADDR_W+1-AM_W){1'b0}}, am_q})
			& ~{{(ADDR_W+1-AM_W){1'b0}}, am_q};
		aend = astart + {{(ADDR_W+1-SIZE_W){1'b0}}, sz_q};
		cend = {1'b0, sel_start_q} + {{(ADDR_W+1-SIZE_W){1'b0}}, sel_len_q};
		pre_diff = astart[ADDR_W-1:0] - sel_start_q;
		suf_diff = cend - aend;
	end

	always_comb begin
		cmd.op    = CMD_HOLD;
		cmd.start = pre_start_q;
		cmd.len   = sz_q;
		cmd.amask = am_q;
		unique case (state_q)
			S_EVAL: cmd.op = CMD_EVAL;
			S_PICK: cmd.op = found_v[CHUNK_SLOTS-1] ? CMD_REMOVE : CMD_HOLD;
			S_INS1: begin
				cmd.op  = (pre_ok_q && !full) ? CMD_INSERT : CMD_HOLD;
				cmd.len = pre_len_q;
			end
			S_INS2: begin
				cmd.op    = (suf_ok_q && !full) ? CMD_INSERT : CMD_HOLD;
				cmd.start = suf_start_q;
				cmd.len   = suf_len_q;
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < CHUNK_SLOTS; i++) begin : g_cell
		chunk_t left_c;
		chunk_t right_c;
		logic   le_l;
		logic   found_l;
		if (i == 0) begin : g_first
			assign left_c  = '0;
			assign le_l    = 1'b1;
			assign found_l = 1'b0;
		end else begin : g_mid
			assign left_c  = chunks[i-1];
			assign le_l    = le_v[i-1];
			assign found_l = found_v[i-1];
		end
		if (i == CHUNK_SLOTS - 1) begin : g_last
			assign right_c = '0;
		end else begin : g_inner
			assign right_c = chunks[i+1];
		end
		bfa_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left       (left_c),
			.right      (right_c),
			.le_left    (le_l),
			.found_left (found_l),
			.chunk      (chunks[i]),
			.le         (le_v[i]),
			.found      (found_v[i]),
			.sel_start  (sel_start[i]),
			.sel_len    (sel_len[i])
		);
		assign cell_v[i] = chunks[i].v;
	end

	// at most one cell drives a nonzero selection
	always_comb begin
		pick_start = '0;
		pick_len   = '0;
		for (int i = 0; i < CHUNK_SLOTS; i++) begin
			pick_start = pick_start | sel_start[i];
			pick_len   = pick_len | sel_len[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= req_type ? S_FCHK : S_EVAL;
				end
				S_EVAL: state_q <= S_PICK;
				S_PICK: begin
					if (found_v[CHUNK_SLOTS-1]) begin
						count_q <= count_q - CW'(1);
						state_q <= S_CALC;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_CALC: state_q <= S_INS1;
				S_INS1: begin
					if (pre_ok_q && !full)
						count_q <= count_q + CW'(1);
					state_q <= S_INS2;
				end
				S_INS2: begin
					if (suf_ok_q && !full)
						count_q <= count_q + CW'(1);
					state_q <= S_OUT;
				end
				S_FCHK: state_q <= free_bad ? S_OUT : S_INS2;
				S_OUT: begin
					if (!out_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					addr_q     <= address;
					sz_q       <= req_type ? size : sz_eff;
					am_q       <= AM_W'(a_full - 32'd1);
					res_addr_q <= '0;
					status_q   <= ST_DONE;
					pre_ok_q   <= 1'b0;
				end
			end
			S_PICK: begin
				sel_start_q <= pick_start;
				sel_len_q   <= pick_len;
				if (!found_v[CHUNK_SLOTS-1])
					status_q <= ST_NOFIT;
			end
			S_CALC: begin
				res_addr_q  <= astart[ADDR_W-1:0];
				pre_start_q <= sel_start_q;
				pre_len_q   <= SIZE_W'(pre_diff);
				pre_ok_q    <= (pre_diff >= ADDR_W'(NODE_BYTES));
				suf_start_q <= aend[ADDR_W-1:0];
				suf_len_q   <= SIZE_W'(suf_diff);
				suf_ok_q    <= (suf_diff >= NB49);
			end
			S_INS1: begin
				if (pre_ok_q && full)
					status_q <= ST_FULL;
			end
			S_INS2: begin
				if (suf_ok_q && full)
					status_q <= ST_FULL;
			end
			S_FCHK: begin
				if (free_bad)
					status_q <= ST_SMALL;
				suf_start_q <= bstart[ADDR_W-1:0];
				suf_len_q   <= SIZE_W'(bend - bstart);
				suf_ok_q    <= 1'b1;
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("chunk count exceeds slot count");
	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_v) == int'(count_q))
		else $error("cell valid bits disagree with chunk count");
	a_nofit_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PICK && !found_v[CHUNK_SLOTS-1]) |=> (out_valid && status == ST_NOFIT))
		else $error("missing no-fit result");
	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !out_valid)
		else $error("result shown right after request");
`endif

endmodule

### tb/sv/tb.sv
// testbench for the best-fit aligned chunk allocator: random and directed requests
// checked against a behavioral model of the sorted free-chunk table; depends on bfa_pkg
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bfa_pkg::*;

	localparam int SLOTS      = 64;
	localparam int NODE_B     = 32;
	localparam int NODE_ALOG  = 3;
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;
	localparam int IDLE_LIMIT = 2000;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] len;
		logic [ALOG_W-1:0] alog;
	} request_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [1:0]        st;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = 1'b0;
	logic [ADDR_W-1:0] address = '0;
	logic [SIZE_W-1:0] size = '0;
	logic [ALOG_W-1:0] align_log2 = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ADDR_W-1:0] alloc_address;
	logic [1:0] status;

	best_fit_aligned_chunk_allocator i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .address(address), .size(size), .align_log2(align_log2),
		.out_valid(out_valid), .out_stall(out_stall), .alloc_address(alloc_address),
		.status(status)
	);

	always #5 clk = ~clk;

	request_t pending[$];
	answer_t  expected_answers[$];
	logic [63:0] pool_start[SLOTS];
	logic [63:0] pool_len[SLOTS];
	int pool_count = 0;
	int errors = 0;
	bit stim_done = 0;
	bit hold_rx = 0;
	int hold_cycles = 0;
	bit pause_tx = 0;

	function automatic bit pool_insert(logic [63:0] s, logic [63:0] l);
		int pos;
		pos = 0;
		if (pool_count >= SLOTS) return 0;
		while (pos < pool_count && pool_len[pos] <= l) pos++;
		for (int i = pool_count; i > pos; i--) begin
			pool_start[i] = pool_start[i-1];
			pool_len[i] = pool_len[i-1];
		end
		pool_start[pos] = s & 64'hFFFF_FFFF_FFFF;
		pool_len[pos] = l & 64'hFF_FFFF_FFFF;
		pool_count++;
		return 1;
	endfunction

	function automatic answer_t predict_allocation(request_t r);
		answer_t a;
		logic [63:0] lim, sz, al, cs, ce, as, ae, na, bs, be;
		int hit;
		lim = 64'd1 << 48;
		a = '0;
		a.st = ST_DONE;
		if (r.kind == REQ_FREE) begin
			na = 64'd1 << NODE_ALOG;
			if (r.len == 0) begin
				a.st = ST_SMALL;
				return a;
			end
			bs = (64'(r.addr) + na - 1) & ~(na - 1);
			be = (64'(r.addr) + 64'(r.len)) & ~(na - 1);
			if (bs + NODE_B > lim || be > lim || be < bs + NODE_B) a.st = ST_SMALL;
			else if (!pool_insert(bs, be - bs)) a.st = ST_FULL;
			return a;
		end
		sz = (r.len < NODE_B) ? 64'(NODE_B) : 64'(r.len);
		al = 64'd1 << ((r.alog < NODE_ALOG) ? NODE_ALOG : r.alog);
		hit = -1;
		for (int i = 0; i < pool_count; i++) begin
			if (pool_len[i] < sz) continue;
			cs = pool_start[i];
			ce = cs + pool_len[i];
			as = (cs + al - 1) & ~(al - 1);
			if (as >= lim) continue;
			ae = as + sz;
			if (ae > lim || ae > ce) continue;
			hit = i;
			break;
		end
		if (hit < 0) begin
			a.st = ST_NOFIT;
			return a;
		end
		for (int i = hit; i + 1 < pool_count; i++) begin
			pool_start[i] = pool_start[i+1];
			pool_len[i] = pool_len[i+1];
		end
		pool_count--;
		if (as - cs >= NODE_B && !pool_insert(cs, as - cs)) a.st = ST_FULL;
		if (ce - ae >= NODE_B && !pool_insert(ae, ce - ae)) a.st = ST_FULL;
		a.addr = as[47:0];
		return a;
	endfunction

	// driver
	int tx_gap = 0;
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			expected_answers.push_back(predict_allocation(
				request_t'{req_type, address, size, align_log2}));
			in_valid <= 1'b0;
			tx_gap = $urandom_range(0, 4);
		end else if (!in_valid) begin
			if (tx_gap > 0) tx_gap--;
			else if (!pause_tx && pending.size() > 0) begin
				request_t r;
				r = pending.pop_front();
				req_type <= r.kind;
				address <= r.addr;
				size <= r.len;
				align_log2 <= r.alog;
				in_valid <= 1'b1;
			end
		end
	end

	// monitor
	int rx_gap = 0;
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			answer_t e;
			if (expected_answers.size() == 0) begin
				$display("%0t: unexpected result addr=%h status=%0d", $time, alloc_address,
					status);
				errors++;
			end else begin
				e = expected_answers.pop_front();
				if (e.addr !== alloc_address) begin
					$display("%0t: alloc_address expected %h actual %h", $time, e.addr,
						alloc_address);
					errors++;
				end
				if (e.st !== status) begin
					$display("%0t: status expected %0d actual %0d", $time, e.st, status);
					errors++;
				end
			end
			rx_gap = $urandom_range(0, 4);
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_stall <= 1'b1;
		end else if (hold_rx) begin
			hold_rx = 0;
			hold_cycles = 300;
			out_stall <= 1'b1;
		end else if (rx_gap > 0) begin
			rx_gap--;
			out_stall <= 1'b1;
		end else out_stall <= 1'b0;
	end

	// watchdog
	int idle = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
		else idle++;
		if (idle >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic request_t free_req(logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] l);
		return request_t'{REQ_FREE, a, l, ALOG_W'($urandom)};
	endfunction

	function automatic request_t alloc_req(logic [SIZE_W-1:0] l, logic [ALOG_W-1:0] g);
		return request_t'{REQ_ALLOC, ADDR_W'({$urandom, $urandom}), l, g};
	endfunction

	function automatic request_t random_req();
		int k;
		logic [ADDR_W-1:0] a;
		logic [SIZE_W-1:0] l;
		k = $urandom_range(0, 99);
		a = ADDR_W'({$urandom, $urandom});
		if (k < 40) begin
			if ($urandom_range(0, 9) == 0) a = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 4095);
			else if ($urandom_range(0, 3) == 0) a = ADDR_W'($urandom);
			l = ($urandom_range(0, 7) == 0) ? SIZE_W'({$urandom, $urandom})
				: SIZE_W'($urandom_range(0, 65536));
			return free_req(a, l);
		end else if (k < 48) begin
			return request_t'{REQ_FREE, a, SIZE_W'({$urandom, $urandom}), ALOG_W'($urandom)};
		end
		l = ($urandom_range(0, 9) == 0) ? SIZE_W'({$urandom, $urandom})
			: SIZE_W'($urandom_range(0, 8192));
		return alloc_req(l, ALOG_W'($urandom_range(0, 9) == 0 ? $urandom_range(0, 31)
			: $urandom_range(0, 12)));
	endfunction

	task automatic wait_drained();
		while (pending.size() > 0 || in_valid || expected_answers.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// directed: edge cases
		pending.push_back(alloc_req(0, 0));                          // empty pool
		pending.push_back(free_req(48'h1000, 0));                     // empty free
		pending.push_back(free_req(48'h1001, 30));                    // too small after align
		pending.push_back(free_req(48'hFFFF_FFFF_FFF0, 40'h100));     // overflowing free
		pending.push_back(free_req(48'hFFFF_FFFF_FFF9, 5));           // no room for node
		pending.push_back(free_req(48'h1003, 40'h1000));
		pending.push_back(free_req(48'h10_0000, 40'hFF_FFFF_FFFF));
		pending.push_back(free_req(48'hFFFF_FFFF_F000, 40'h1000));    // ends exactly at top
		pending.push_back(alloc_req(1, 0));                           // minimums
		pending.push_back(alloc_req(64, 8));                          // prefix remnant
		pending.push_back(alloc_req(40'hFF_FFFF_FFFF, 31));           // large align
		pending.push_back(alloc_req(40'h100, 5'd31));
		pending.push_back(alloc_req(40'h800, 20));                    // wrap skip
		pending.push_back(alloc_req(40'hFF_F000_0000, 0));
		for (int i = 0; i < 70; i++)                                  // fill to full
			pending.push_back(free_req(48'h2000_0000 + i * 48'h1_0000, 40'h1000));
		pending.push_back(alloc_req(40'h100, 10));                    // remnants dropped
		wait_drained();
		// long receiver hold-off while sender keeps offering
		hold_rx = 1;
		for (int i = 0; i < 40; i++) pending.push_back(random_req());
		wait_drained();
		pause_tx = 1;
		for (int i = 0; i < 1000; i++) begin
			if (i == 500) begin
				wait_drained();
				pause_tx = 1;
			end
			pending.push_back(random_req());
			if (i % 10 == 0) pause_tx = 0;
		end
		pause_tx = 0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule
